/* hdl/srtn_pkg.sv */
// Shared types and constants for the shortest-remaining-time scheduler.
// Depends on nothing; every other file of the block refers to it by scoped names.
package srtn_pkg;

   // Widths of the transaction fields.
   localparam int OP_W         = 1;
   localparam int SLOT_W       = 3;
   localparam int BURST_W      = 16;
   localparam int TIME_UNIT_W  = 16;
   localparam int TURNAROUND_W = 17;

   // Operation codes of a request transaction.
   localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
   localparam logic [OP_W-1:0] OP_TICK = 1'b1;

   // Sequencer states of the top level.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY
   } state_type;

   // Per-cell command from the sequencer.
   typedef struct packed {
      logic load;    // write this cell with a new burst
      logic apply;   // a tick picked some cell and updates the table now
      logic picked;  // this cell is the one that runs on this tick
   } cell_ctl_type;

endpackage

/* hdl/srtn_if.sv */
// Handshake interfaces of the scheduler: request channel and response channel.
// Depends on srtn_pkg for the field widths.
interface srtn_req_if;
   logic                            valid;
   logic                            ready;
   logic [srtn_pkg::OP_W-1:0]       operation;
   logic [srtn_pkg::SLOT_W-1:0]     slot;
   logic [srtn_pkg::BURST_W-1:0]    burst;

   modport source (output valid, output operation, output slot, output burst, input ready);
   modport sink   (input valid, input operation, input slot, input burst, output ready);
endinterface

interface srtn_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               ran_valid;
   logic [srtn_pkg::SLOT_W-1:0]        ran_slot;
   logic [srtn_pkg::TIME_UNIT_W-1:0]   time_unit;
   logic                               finished;
   logic [srtn_pkg::TURNAROUND_W-1:0]  turnaround;
   logic                               all_done;

   modport source (output valid, output ran_valid, output ran_slot, output time_unit,
                   output finished, output turnaround, output all_done, input ready);
   modport sink   (input valid, input ran_valid, input ran_slot, input time_unit,
                   input finished, input turnaround, input all_done, output ready);
endinterface

/* hdl/srtn_cell.sv */
// One process slot of the scheduler: holds remaining, waiting and burst time
// and forwards the running minimum to its neighbor. Depends on srtn_pkg.
module srtn_cell #(
   parameter int INDEX      = 0,
   parameter int TIME_WIDTH = 16,
   parameter int IDX_W      = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   input  srtn_pkg::cell_ctl_type    ctl,
   input  logic [TIME_WIDTH-1:0]     load_burst,
   input  logic                      cin_valid,
   input  logic [TIME_WIDTH-1:0]     cin_rem,
   input  logic [IDX_W-1:0]          cin_idx,
   input  logic [TIME_WIDTH:0]       cin_sum,
   output logic                      cout_valid_ff,
   output logic [TIME_WIDTH-1:0]     cout_rem_ff,
   output logic [IDX_W-1:0]          cout_idx_ff,
   output logic [TIME_WIDTH:0]       cout_sum_ff
);

   logic [TIME_WIDTH-1:0] rem_ff, rem_in;
   logic [TIME_WIDTH-1:0] wait_ff, wait_in;
   logic [TIME_WIDTH-1:0] burst_ff, burst_in;
   logic                  done_ff, done_in;
   logic [TIME_WIDTH:0]   own_sum;
   logic                  take_own;

   // Turnaround candidate of this slot, one bit wider than a time value.
   assign own_sum  = {1'b0, wait_ff} + {1'b0, burst_ff};
   // Replace the incoming minimum only on a strictly smaller remaining time,
   // so that ties stay with the lower index.
   assign take_own = !done_ff && (!cin_valid || (rem_ff < cin_rem));

   always_comb begin
      rem_in   = rem_ff;
      wait_in  = wait_ff;
      burst_in = burst_ff;
      done_in  = done_ff;
      if (ctl.load) begin
         rem_in   = load_burst;
         burst_in = load_burst;
         wait_in  = '0;
         done_in  = (load_burst == '0);
      end else if (ctl.apply) begin
         if (ctl.picked) begin
            if (rem_ff != '0) begin
               rem_in = rem_ff - 1'b1;
            end
            if (rem_ff <= TIME_WIDTH'(1)) begin
               done_in = 1'b1;
            end
         end else if (!done_ff && (wait_ff != '1)) begin
            wait_in = wait_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff       <= 1'b1;
         cout_valid_ff <= 1'b0;
      end else begin
         done_ff       <= done_in;
         cout_valid_ff <= cin_valid || !done_ff;
      end
      rem_ff   <= rem_in;
      wait_ff  <= wait_in;
      burst_ff <= burst_in;
      if (take_own) begin
         cout_rem_ff <= rem_ff;
         cout_idx_ff <= IDX_W'(INDEX);
         cout_sum_ff <= own_sum;
      end else begin
         cout_rem_ff <= cin_rem;
         cout_idx_ff <= cin_idx;
         cout_sum_ff <= cin_sum;
      end
   end

endmodule

/* hdl/srtn_process_scheduler_core.sv */
// Top level of the shortest-remaining-time-first process scheduler.
// Depends on srtn_pkg, srtn_req_if / srtn_rsp_if and srtn_cell.
//
//   Channel    Direction  Handshake        Payload
//   req_chan   in         valid / ready    operation, slot, burst
//   rsp_chan   out        valid / ready    ran_valid, ran_slot, time_unit,
//                                          finished, turnaround, all_done
//
// A load transaction updates its slot in the accept cycle; its all-zero response
// appears in the following cycle; loads stream one per cycle while rsp is ready.
// A tick transaction passes through a scan state and an update state: the minimum
// travels through the chain of slot cells one cell per cycle, then the update state
// applies the run and waiting updates and loads the response register.
// Reset is synchronous and active high; it marks every slot finished and
// clears the elapsed-time counter. A stalled response holds the block in place:
// no request is taken and a pending tick waits in its update cycle.
module srtn_process_scheduler_core #(
   parameter int SLOTS      = 8,
   parameter int TIME_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   srtn_req_if.sink          req_chan,
   srtn_rsp_if.source        rsp_chan
);

   localparam int IDX_W = $clog2(SLOTS);

   // Sequencer state and scan counter.
   srtn_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]    scan_cnt_ff, scan_cnt_in;
   logic [TIME_WIDTH-1:0] step_count_ff, step_count_in;

   // Response register.
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                ran_valid_ff, ran_valid_in;
   logic [srtn_pkg::SLOT_W-1:0]         ran_slot_ff, ran_slot_in;
   logic [srtn_pkg::TIME_UNIT_W-1:0]    time_unit_ff, time_unit_in;
   logic                                finished_ff, finished_in;
   logic [srtn_pkg::TURNAROUND_W-1:0]   turnaround_ff, turnaround_in;
   logic                                all_done_ff, all_done_in;

   // Chain of running minimum records; element k feeds cell k.
   logic                  chain_valid [SLOTS+1];
   logic [TIME_WIDTH-1:0] chain_rem   [SLOTS+1];
   logic [IDX_W-1:0]      chain_idx   [SLOTS+1];
   logic [TIME_WIDTH:0]   chain_sum   [SLOTS+1];

   logic                  out_free;
   logic                  req_accept;
   logic                  load_accept;
   logic                  tick_accept;
   logic                  apply_go;
   logic [TIME_WIDTH-1:0] load_burst;
   logic [31:0]           slot_wide;
   logic                  best_valid;
   logic [TIME_WIDTH-1:0] best_rem;
   logic [IDX_W-1:0]      best_idx;
   logic [TIME_WIDTH:0]   best_sum;
   logic                  best_finishes;

   // The response register can take a new transaction when it is empty or
   // being drained in this cycle.
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == srtn_pkg::ST_IDLE) && out_free;
   assign req_accept  = req_chan.valid && req_chan.ready;
   assign load_accept = req_accept && (req_chan.operation == srtn_pkg::OP_LOAD);
   assign tick_accept = req_accept && (req_chan.operation == srtn_pkg::OP_TICK);

   // The burst field is masked or zero-extended to the time width.
   assign load_burst = TIME_WIDTH'({{TIME_WIDTH{1'b0}}, req_chan.burst});
   assign slot_wide  = 32'(req_chan.slot);

   // Nothing enters the head of the chain.
   assign chain_valid[0] = 1'b0;
   assign chain_rem[0]   = '0;
   assign chain_idx[0]   = '0;
   assign chain_sum[0]   = '0;

   assign best_valid = chain_valid[SLOTS];
   assign best_rem   = chain_rem[SLOTS];
   assign best_idx   = chain_idx[SLOTS];
   assign best_sum   = chain_sum[SLOTS];
   // The picked slot reaches zero on this unit when one unit or less is left.
   assign best_finishes = (best_rem <= TIME_WIDTH'(1));

   // The table is updated only when the tick found a slot to run.
   assign apply_go = (state_ff == srtn_pkg::ST_APPLY) && out_free && best_valid;

   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      srtn_pkg::cell_ctl_type ctl;

      assign ctl.load   = load_accept && (slot_wide == 32'(k));
      assign ctl.apply  = apply_go;
      assign ctl.picked = (best_idx == IDX_W'(k));

      srtn_cell #(
         .INDEX      (k),
         .TIME_WIDTH (TIME_WIDTH),
         .IDX_W      (IDX_W)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (ctl),
         .load_burst    (load_burst),
         .cin_valid     (chain_valid[k]),
         .cin_rem       (chain_rem[k]),
         .cin_idx       (chain_idx[k]),
         .cin_sum       (chain_sum[k]),
         .cout_valid_ff (chain_valid[k+1]),
         .cout_rem_ff   (chain_rem[k+1]),
         .cout_idx_ff   (chain_idx[k+1]),
         .cout_sum_ff   (chain_sum[k+1])
      );
   end

   // Sequencer: the table holds still during the scan, so at the end of the scan the
   // record at the tail of the chain is the minimum over all slots.
   always_comb begin
      state_in      = state_ff;
      scan_cnt_in   = scan_cnt_ff;
      step_count_in = step_count_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      ran_valid_in  = ran_valid_ff;
      ran_slot_in   = ran_slot_ff;
      time_unit_in  = time_unit_ff;
      finished_in   = finished_ff;
      turnaround_in = turnaround_ff;
      all_done_in   = all_done_ff;

      unique case (state_ff)
         srtn_pkg::ST_IDLE: begin
            if (load_accept) begin
               rsp_valid_in  = 1'b1;
               ran_valid_in  = 1'b0;
               ran_slot_in   = '0;
               time_unit_in  = '0;
               finished_in   = 1'b0;
               turnaround_in = '0;
               all_done_in   = 1'b0;
            end else if (tick_accept) begin
               state_in    = srtn_pkg::ST_SCAN;
               scan_cnt_in = '0;
            end
         end
         srtn_pkg::ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (scan_cnt_ff == IDX_W'(SLOTS - 1)) begin
               state_in = srtn_pkg::ST_APPLY;
            end
         end
         srtn_pkg::ST_APPLY: begin
            if (out_free) begin
               state_in     = srtn_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               if (best_valid) begin
                  step_count_in = step_count_ff + 1'b1;
                  ran_valid_in  = 1'b1;
                  ran_slot_in   = srtn_pkg::SLOT_W'({{srtn_pkg::SLOT_W{1'b0}}, best_idx});
                  time_unit_in  = srtn_pkg::TIME_UNIT_W'(
                                     {{srtn_pkg::TIME_UNIT_W{1'b0}}, step_count_ff});
                  finished_in   = best_finishes;
                  turnaround_in = best_finishes
                                ? srtn_pkg::TURNAROUND_W'(
                                     {{srtn_pkg::TURNAROUND_W{1'b0}}, best_sum})
                                : '0;
                  all_done_in   = 1'b0;
               end else begin
                  ran_valid_in  = 1'b0;
                  ran_slot_in   = '0;
                  time_unit_in  = '0;
                  finished_in   = 1'b0;
                  turnaround_in = '0;
                  all_done_in   = 1'b1;
               end
            end
         end
         default: begin
            state_in = srtn_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= srtn_pkg::ST_IDLE;
         scan_cnt_ff   <= '0;
         step_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_cnt_ff   <= scan_cnt_in;
         step_count_ff <= step_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      ran_valid_ff  <= ran_valid_in;
      ran_slot_ff   <= ran_slot_in;
      time_unit_ff  <= time_unit_in;
      finished_ff   <= finished_in;
      turnaround_ff <= turnaround_in;
      all_done_ff   <= all_done_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.ran_valid  = ran_valid_ff;
   assign rsp_chan.ran_slot   = ran_slot_ff;
   assign rsp_chan.time_unit  = time_unit_ff;
   assign rsp_chan.finished   = finished_ff;
   assign rsp_chan.turnaround = turnaround_ff;
   assign rsp_chan.all_done   = all_done_ff;

   // A response never claims both a run and an empty table.
   a_run_excludes_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(ran_valid_ff && all_done_ff))
      else $error("response reports a run and all_done together");

   // A finish can only be reported for a slot that ran.
   a_finish_needs_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && finished_ff) |-> ran_valid_ff)
      else $error("finish reported without a run");

   // Elapsed time moves only in the update cycle of a tick.
   a_step_only_on_apply: assert property (@(posedge clock) disable iff (reset)
      (state_ff != srtn_pkg::ST_APPLY) |=> $stable(step_count_ff))
      else $error("step counter changed outside the update cycle");

   // An accepted tick always starts a scan of the chain.
   a_tick_starts_scan: assert property (@(posedge clock) disable iff (reset)
      tick_accept |=> (state_ff == srtn_pkg::ST_SCAN))
      else $error("accepted tick did not start a scan");

endmodule
